### rtl/core/cast_pkg.sv
// Shared types, codes and constants for the chunk activity sleep tracker.
`timescale 1ns / 1ps
package cast_pkg;
  localparam int CHUNK_EDGE_DEF = 64;
  localparam int MAX_COLS_DEF   = 16;
  localparam int MAX_ROWS_DEF   = 16;

  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SLEEP_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    REQ_START = 3'd0,
    REQ_CHANGE = 3'd1,
    REQ_END = 3'd2,
    REQ_WAKE = 3'd3,
    REQ_QUERY = 3'd4
  } req_t;

  // op handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_NONE, OP_START, OP_CHANGE, OP_END, OP_WAKE, OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAKE, ST_WALK, ST_SEND, ST_CLEAR
  } st_t;

  typedef struct packed {
    op_t        op;
    logic       hit;   // position lies inside the grid
    logic [5:0] cx;
    logic [5:0] cy;
  } cmd_t;
endpackage

### rtl/core/cast_front.sv
// Front end: accepts beats, decodes the request and locates the chunk.
`timescale 1ns / 1ps
module cast_front #(
  parameter int CHUNK_EDGE = cast_pkg::CHUNK_EDGE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            req_type,
  input  logic [9:0]            pos_x,
  input  logic [9:0]            pos_y,
  input  logic [10:0]           world_width,
  input  logic [10:0]           world_height,
  input  logic [6:0]            cols,
  input  logic [6:0]            rows,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cast_pkg::cmd_t        cmd
);
  import cast_pkg::*;
  localparam int SH = $clog2(CHUNK_EDGE);

  // two-entry queue toward the back end
  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic [10:0] cxw, cyw;
  logic       push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // classify the request and find its chunk
  always_comb begin
    cxw = 11'({1'b0, pos_x} >> SH);
    cyw = 11'({1'b0, pos_y} >> SH);
    dec.cx  = cxw[5:0];
    dec.cy  = cyw[5:0];
    dec.hit = ({1'b0, pos_x} < world_width) && ({1'b0, pos_y} < world_height)
              && (cxw < 11'(cols)) && (cyw < 11'(rows));
    unique case (req_type)
      REQ_START:  dec.op = OP_START;
      REQ_CHANGE: dec.op = OP_CHANGE;
      REQ_END:    dec.op = OP_END;
      REQ_WAKE:   dec.op = OP_WAKE;
      REQ_QUERY:  dec.op = OP_QUERY;
      default:    dec.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= dec;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2)
    else $error("full queue lost an entry");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !push) |=> !cmd_valid)
    else $error("empty queue shows data");
endmodule

### rtl/core/cast_back.sv
// Back end: per-chunk state, wake sweeps, end-of-tick walk and result register.
`timescale 1ns / 1ps
module cast_back #(
  parameter int MAX_COLS = cast_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = cast_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cast_pkg::cmd_t cmd,
  input  logic [6:0]     cols,
  input  logic [6:0]     rows,
  input  logic [15:0]    sleep_limit,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [28:0]    out_data
);
  import cast_pkg::*;
  localparam int SLOTS = MAX_COLS * MAX_ROWS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = IW + 1;

  // flags in flip-flops, counters and revisions in memories
  logic [SLOTS-1:0] active, changed, snap, quiet_ok;
  logic [15:0] quiet_mem [SLOTS];
  logic [31:0] rev_mem [SLOTS];

  st_t         st, st_next;
  cmd_t        cur;
  logic [1:0]  ndx, ndy;    // neighbor offset plus one
  logic        last_nb;
  logic [CW-1:0] idx;
  logic [CW-1:0] total;
  logic [8:0]  n_act, n_slp, n_chg;
  logic        wk;          // index is a neighbor to wake this cycle
  logic [7:0]  ncx, ncy;
  logic [IW-1:0] waddr;
  logic [IW-1:0] ia;        // walk read address
  logic [IW-1:0] ib;        // chunk whose memory data is back
  logic        wv;          // ib holds a chunk to update
  logic [15:0] rd_q, qv, qinc;
  logic [31:0] rd_r;
  logic        now_act;
  logic        q_we, r_we;
  logic [IW-1:0] r_wa;
  logic [31:0] r_wd;

  assign total     = CW'(cols) * CW'(rows);
  assign cmd_ready = (st == ST_IDLE) && !out_valid;
  assign ia        = idx[IW-1:0];
  assign last_nb   = (ndx == 2'd2) && (ndy == 2'd2);

  // neighbor coordinates for the change sweep
  always_comb begin
    ncx = 8'(cur.cx) + 8'(ndx) - 8'd1;
    ncy = 8'(cur.cy) + 8'(ndy) - 8'd1;
    wk = (ncx < 8'(cols)) && (ncy < 8'(rows));
    waddr = IW'(16'(ncy) * 16'(cols) + 16'(ncx));
  end

  // update stage of the walk; cleared quiet counters read as zero
  always_comb begin
    qv = quiet_ok[ib] ? rd_q : 16'd0;
    qinc = (qv != 16'hFFFF) ? qv + 16'd1 : qv;
    now_act = changed[ib] || (active[ib] && !(snap[ib] && (qinc >= sleep_limit)));
    q_we = (st == ST_WALK) && wv && !changed[ib] && snap[ib];
    r_we = (st == ST_CLEAR) || ((st == ST_WALK) && wv && changed[ib]);
    r_wa = (st == ST_CLEAR) ? ia : ib;
    r_wd = (st == ST_CLEAR) ? 32'd0 : rd_r + 32'd1;
  end

  // counter and revision memories, registered read at the walk index
  always_ff @(posedge clk) begin
    rd_q <= quiet_mem[ia];
    rd_r <= rev_mem[ia];
    if (q_we) quiet_mem[ib] <= qinc;
    if (r_we) rev_mem[r_wa] <= r_wd;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (ia == IW'(SLOTS - 1)) st_next = ST_IDLE;
      ST_IDLE: if (cmd_valid && cmd_ready) begin
        if (cmd.op == OP_CHANGE && cmd.hit) st_next = ST_WAKE;
        else if (cmd.op == OP_END) st_next = (total == '0) ? ST_SEND : ST_WALK;
      end
      ST_WAKE: if (last_nb) st_next = ST_IDLE;
      ST_WALK: if (wv && idx == total) st_next = ST_SEND;
      ST_SEND: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_CLEAR;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '1;
      changed <= '0;
      snap <= '0;
      quiet_ok <= '0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        // zero the revisions after reset, one entry per cycle
        ST_CLEAR: idx <= idx + CW'(1);
        ST_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd;
          ndx <= 2'd0;
          ndy <= 2'd0;
          idx <= '0;
          wv <= 1'b0;
          n_act <= '0;
          n_slp <= '0;
          n_chg <= '0;
          out_valid <= (cmd.op != OP_END) && !(cmd.op == OP_CHANGE && cmd.hit);
          out_data <= {cmd.op == OP_QUERY && cmd.hit &&
                       snap[IW'(16'(cmd.cy) * 16'(cols) + 16'(cmd.cx))], 28'd0};
          case (cmd.op)
            OP_START: snap <= active;
            OP_WAKE: begin
              active <= '1;
              quiet_ok <= '0;
            end
            OP_CHANGE: if (cmd.hit)
              changed[IW'(16'(cmd.cy) * 16'(cols) + 16'(cmd.cx))] <= 1'b1;
            default: ;
          endcase
        end
        ST_WAKE: begin
          if (wk) begin
            active[waddr] <= 1'b1;
            quiet_ok[waddr] <= 1'b0;
          end
          if (ndx == 2'd2) begin
            ndx <= 2'd0;
            ndy <= ndy + 2'd1;
          end else begin
            ndx <= ndx + 2'd1;
          end
          if (last_nb) out_valid <= 1'b1;
        end
        // read chunk idx while updating the chunk read in the previous cycle
        ST_WALK: begin
          if (idx != total) idx <= idx + CW'(1);
          wv <= (idx != total);
          ib <= ia;
          if (wv) begin
            if (changed[ib]) begin
              quiet_ok[ib] <= 1'b0;
              active[ib] <= 1'b1;
              changed[ib] <= 1'b0;
              n_chg <= n_chg + 9'd1;
            end else if (snap[ib]) begin
              quiet_ok[ib] <= 1'b1;
              if (qinc >= sleep_limit) active[ib] <= 1'b0;
            end
            if (now_act) n_act <= n_act + 9'd1;
            else n_slp <= n_slp + 9'd1;
          end
        end
        ST_SEND: begin
          out_data <= {1'b0, n_chg, n_slp, n_act, 1'b1};
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> !cmd_ready)
    else $error("command taken while busy");
  a_send: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SEND) |=> (out_valid && out_data[0]))
    else $error("end-of-tick result missing");
endmodule

### rtl/core/chunk_activity_sleep_tracker.sv
// Top level of the chunk activity sleep tracker.
// Usage: request beats enter on s_axis (tdata = req_type, pos_x, pos_y).
// Each beat yields exactly one result beat on m_axis, in order.
// Configuration writes (cfg_index 0 width, 1 height, 2 sleep limit) go on
// the cfg channel while the block is idle; cfg_ready is always high.
// Flow: a front end decodes and locates the chunk and feeds a two-entry
// queue; the back end runs one item at a time and takes the next command
// once the result beat has left. A cell change runs a 9-step neighbor
// sweep; end of tick walks one chunk per cycle behind a registered memory
// read, then sends the count beat.
// Reset restores register defaults and marks all chunks active with zeroed
// counters; the back end then zeroes the MAX_COLS*MAX_ROWS revisions (256 by
// default), while the queue takes up to two beats.
// When m_axis stalls, the result is held and the back end stops taking
// commands; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
module chunk_activity_sleep_tracker #(
  parameter int CHUNK_EDGE = cast_pkg::CHUNK_EDGE_DEF,
  parameter int MAX_COLS = cast_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = cast_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // req_type[2:0], pos_x[12:3], pos_y[22:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tick_done[0], active_count[9:1], sleeping_count[18:10],
  // changed_count[27:19], started_active[28]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cast_pkg::*;
  localparam int SH = $clog2(CHUNK_EDGE);

  logic [10:0] world_width, world_height;
  logic [15:0] sleep_limit, lim;
  logic [6:0]  cols, rows;
  logic [11:0] cw, rh;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [28:0] res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width <= 11'd1024;
      world_height <= 11'd1024;
      sleep_limit <= 16'd60;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WORLD_WIDTH:  world_width <= cfg_data[10:0];
        REG_WORLD_HEIGHT: world_height <= cfg_data[10:0];
        REG_SLEEP_LIMIT:  sleep_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid size, capped
  always_comb begin
    cw = (12'(world_width) + 12'(CHUNK_EDGE - 1)) >> SH;
    rh = (12'(world_height) + 12'(CHUNK_EDGE - 1)) >> SH;
    cols = (cw > 12'(MAX_COLS)) ? 7'(MAX_COLS) : cw[6:0];
    rows = (rh > 12'(MAX_ROWS)) ? 7'(MAX_ROWS) : rh[6:0];
    lim = (sleep_limit == 16'd0) ? 16'd1 : sleep_limit;
  end

  cast_front #(.CHUNK_EDGE(CHUNK_EDGE)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tdata[2:0]), .pos_x(s_axis_tdata[12:3]), .pos_y(s_axis_tdata[22:13]),
    .world_width, .world_height, .cols, .rows,
    .cmd_valid, .cmd_ready, .cmd
  );

  cast_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .cols, .rows,
    .sleep_limit(lim), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(res)
  );

  assign m_axis_tdata = {3'b000, res};
endmodule

### tb/testbench.sv
// Testbench for the chunk activity sleep tracker: directed table, then random ticks.
`timescale 1ns / 1ps
module testbench;
  import cast_pkg::*;

  localparam int EDGE = CHUNK_EDGE_DEF;
  localparam int MAXC = MAX_COLS_DEF;
  localparam int MAXR = MAX_ROWS_DEF;
  localparam int SLOTS = MAXC * MAXR;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic       tick_done;
    logic [8:0] active_count;
    logic [8:0] sleeping_count;
    logic [8:0] changed_count;
    logic       started_active;
  } result_t;

  typedef struct {
    logic [2:0] kind;
    logic [9:0] x;
    logic [9:0] y;
    logic       typed;
    result_t    res;
  } row_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  chunk_activity_sleep_tracker i_dut (.*);

  // tracker mirror state
  logic [10:0] world_w, world_h;
  logic [15:0] quiet_limit;
  logic        act_q[SLOTS];
  logic        chg_q[SLOTS];
  logic [15:0] quiet_q[SLOTS];
  logic        snap_q[SLOTS];

  result_t expected_results[$];
  row_t rows[$];
  int errors = 0;
  int results_seen = 0;
  int ticks_seen = 0;
  int cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;

  function automatic int cols_of();
    int c;
    c = (world_w + EDGE - 1) / EDGE;
    return c > MAXC ? MAXC : c;
  endfunction

  function automatic int rows_of();
    int r;
    r = (world_h + EDGE - 1) / EDGE;
    return r > MAXR ? MAXR : r;
  endfunction

  function automatic bit find_chunk(input logic [9:0] x, input logic [9:0] y,
                                    output int cx, output int cy);
    cx = x / EDGE;
    cy = y / EDGE;
    if (x >= world_w || y >= world_h) return 0;
    return cx < cols_of() && cy < rows_of();
  endfunction

  function automatic result_t track_item(input logic [2:0] kind, input logic [9:0] x,
                                         input logic [9:0] y);
    result_t r;
    int cx, cy, nc, nr, idx, na, ns, nch;
    r = '0;
    nc = cols_of();
    nr = rows_of();
    case (kind)
      REQ_START: for (int i = 0; i < SLOTS; i++) snap_q[i] = act_q[i];
      REQ_CHANGE: if (find_chunk(x, y, cx, cy)) begin
        chg_q[cy * nc + cx] = 1;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (cx + dx >= 0 && cy + dy >= 0 && cx + dx < nc && cy + dy < nr) begin
              idx = (cy + dy) * nc + cx + dx;
              act_q[idx] = 1;
              quiet_q[idx] = 0;
            end
      end
      REQ_END: begin
        na = 0; ns = 0; nch = 0;
        for (int i = 0; i < nc * nr; i++) begin
          if (chg_q[i]) begin
            quiet_q[i] = 0; act_q[i] = 1; chg_q[i] = 0; nch++;
          end else if (snap_q[i]) begin
            if (quiet_q[i] != 16'hFFFF) quiet_q[i]++;
            if (quiet_q[i] >= quiet_limit) act_q[i] = 0;
          end
          if (act_q[i]) na++; else ns++;
        end
        r.tick_done = 1;
        r.active_count = na[8:0];
        r.sleeping_count = ns[8:0];
        r.changed_count = nch[8:0];
      end
      REQ_WAKE: for (int i = 0; i < SLOTS; i++) begin
        act_q[i] = 1; quiet_q[i] = 0;
      end
      REQ_QUERY: if (find_chunk(x, y, cx, cy)) r.started_active = snap_q[cy * nc + cx];
      default: ;
    endcase
    return r;
  endfunction

  // clock, cycle limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout at %0t", $time);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.tick_done = m_axis_tdata[0];
      got.active_count = m_axis_tdata[9:1];
      got.sleeping_count = m_axis_tdata[18:10];
      got.changed_count = m_axis_tdata[27:19];
      got.started_active = m_axis_tdata[28];
      results_seen++;
      if (got.tick_done) ticks_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.tick_done !== want.tick_done) begin
          $display("%0t: tick_done exp %0d got %0d", $time, want.tick_done, got.tick_done);
          errors++;
        end
        if (got.active_count !== want.active_count) begin
          $display("%0t: active_count exp %0d got %0d", $time,
                   want.active_count, got.active_count);
          errors++;
        end
        if (got.sleeping_count !== want.sleeping_count) begin
          $display("%0t: sleeping_count exp %0d got %0d", $time,
                   want.sleeping_count, got.sleeping_count);
          errors++;
        end
        if (got.changed_count !== want.changed_count) begin
          $display("%0t: changed_count exp %0d got %0d", $time,
                   want.changed_count, got.changed_count);
          errors++;
        end
        if (got.started_active !== want.started_active) begin
          $display("%0t: started_active exp %0d got %0d", $time,
                   want.started_active, got.started_active);
          errors++;
        end
      end
    end
  end

  task automatic add_row(input logic [2:0] kind, input logic [9:0] x, input logic [9:0] y,
                         input logic typed, input result_t res);
    row_t r;
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.res = res;
    rows.insert(rows.size(), r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_WORLD_WIDTH: world_w = val[10:0];
      REG_WORLD_HEIGHT: world_h = val[10:0];
      REG_SLEEP_LIMIT: quiet_limit = val;
      default: ;
    endcase
  endtask

  // one request beat; expectation queued at acceptance, valid left high
  task automatic send_req(input logic [2:0] kind, input logic [9:0] x, input logic [9:0] y,
                          input bit typed, input result_t res);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, y, x, kind};
    do @(posedge clk); while (!s_axis_tready);
    pred = track_item(kind, x, y);
    if (typed && pred !== res) begin
      $display("%0t: table row exp %h, tracker %h", $time, res, pred);
      errors++;
    end
    expected_results.insert(expected_results.size(), pred);
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // one random tick: start, a mix of changes, queries, wakes, starts and other kinds, end
  task automatic random_tick(input int n, input int wmax, input int hmax);
    logic [2:0] k;
    int p;
    send_req(REQ_START, 10'($urandom), 10'($urandom), 0, '0);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 50) k = REQ_CHANGE;
      else if (p < 85) k = REQ_QUERY;
      else if (p < 90) k = REQ_WAKE;
      else if (p < 95) k = REQ_START;
      else k = 3'($urandom_range(7));
      if ($urandom_range(9) == 0)
        send_req(k, 10'($urandom), 10'($urandom), 0, '0);
      else
        send_req(k, 10'($urandom_range(wmax)), 10'($urandom_range(hmax)), 0, '0);
    end
    send_req(REQ_END, 10'($urandom), 10'($urandom), 0, '0);
  endtask

  initial begin
    row_t rw;
    int lims[4];
    int sizes[6];
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    world_w = 1024; world_h = 1024; quiet_limit = 60;
    for (int i = 0; i < SLOTS; i++) begin
      act_q[i] = 1; chg_q[i] = 0; quiet_q[i] = 0; snap_q[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed table: typed rows are obvious from the defaults
    add_row(REQ_QUERY, 10'd0, 10'd0, 1, '0);                   // snapshot empty
    add_row(REQ_END, 10'd0, 10'd0, 1, '{1, 256, 0, 0, 0});     // all 256 chunks active
    add_row(REQ_START, 10'd0, 10'd0, 1, '0);
    add_row(REQ_QUERY, 10'd1023, 10'd1023, 1, '{0, 0, 0, 0, 1});
    add_row(REQ_CHANGE, 10'd0, 10'd0, 1, '0);
    add_row(REQ_CHANGE, 10'd1023, 10'd1023, 1, '0);
    add_row(REQ_CHANGE, 10'd500, 10'd300, 1, '0);
    add_row(3'd5, 10'h3FF, 10'h3FF, 1, '0);
    add_row(3'd6, 10'h155, 10'h2AA, 1, '0);
    add_row(3'd7, 10'h2AA, 10'h155, 1, '0);
    add_row(REQ_END, 10'd0, 10'd0, 0, '0);
    add_row(REQ_WAKE, 10'd0, 10'd0, 1, '0);
    for (int i = 0; i < rows.size(); i++) begin
      rw = rows[i];
      send_req(rw.kind, rw.x, rw.y, rw.typed, rw.res);
    end
    s_axis_tvalid <= 0;
    drain();

    // small world, limit 1 (zero acts as one), out-of-grid positions
    write_reg(REG_WORLD_WIDTH, 16'd100);
    write_reg(REG_WORLD_HEIGHT, 16'd1);
    write_reg(REG_SLEEP_LIMIT, 16'd0);
    rows.delete();
    add_row(REQ_START, 10'd0, 10'd0, 1, '0);
    add_row(REQ_QUERY, 10'd99, 10'd0, 0, '0);
    add_row(REQ_QUERY, 10'd100, 10'd0, 1, '0);
    add_row(REQ_QUERY, 10'd0, 10'd1, 1, '0);
    add_row(REQ_CHANGE, 10'd100, 10'd0, 1, '0);
    add_row(REQ_END, 10'd0, 10'd0, 1, '{1, 0, 2, 0, 0});
    add_row(REQ_START, 10'd0, 10'd0, 1, '0);
    add_row(REQ_CHANGE, 10'd64, 10'd0, 1, '0);
    add_row(REQ_END, 10'd0, 10'd0, 1, '{1, 2, 0, 1, 0});
    for (int i = 0; i < rows.size(); i++) begin
      rw = rows[i];
      send_req(rw.kind, rw.x, rw.y, rw.typed, rw.res);
    end
    s_axis_tvalid <= 0;
    drain();
    // zero-size grid
    write_reg(REG_WORLD_WIDTH, 16'd0);
    send_req(REQ_CHANGE, 10'd0, 10'd0, 1, '0);
    send_req(REQ_END, 10'd0, 10'd0, 1, '{1, 0, 0, 0, 0});
    s_axis_tvalid <= 0;
    drain();

    // random phases over several world sizes and limits
    lims = '{1, 2, 5, 65535};
    sizes = '{1, 64, 65, 200, 1024, 2047};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 36 : 0;
      for (int s = 0; s < 6; s++) begin
        write_reg(REG_WORLD_WIDTH, 16'(sizes[$urandom_range(5)]));
        write_reg(REG_WORLD_HEIGHT, 16'(sizes[$urandom_range(5)]));
        write_reg(REG_SLEEP_LIMIT, 16'(lims[$urandom_range(3)]));
        for (int t = 0; t < 8; t++) random_tick($urandom_range(3, 16), 1023, 1023);
        s_axis_tvalid <= 0;
        drain();
      end
    end

    // long receiver hold-off while requests keep coming
    @(negedge clk);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 20; i++)
          send_req(REQ_QUERY, 10'($urandom), 10'($urandom), 0, '0);
        s_axis_tvalid <= 0;
      end
    join
    drain();

    $display("Checked %0d result beats, %0d of them end-of-tick walks, over several grids,",
             results_seen, ticks_seen);
    $display("sleep limits, idle mixes and a long receiver stall.");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
